// ===== design/indexed_binary_max_heap_core_defines.svh =====
// Assertion macros used by the heap sequencer module.
`ifndef INDEXED_BINARY_MAX_HEAP_CORE_DEFINES_SVH
`define INDEXED_BINARY_MAX_HEAP_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IBH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("heap core check failed");

// Next-cycle implication, checked outside reset.
`define IBH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("heap core check failed");

`endif

// ===== design/ibh_pkg.sv =====
// Types and codes shared by the indexed max-heap core.
`default_nettype none
package ibh_pkg;

    localparam int CAPACITY   = 256;
    localparam int NODE_COUNT = 256;
    localparam int KEY_BITS   = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_UPDATE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_PRESENT = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  node_id;
        logic [15:0] key;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  top_node;
        logic [15:0] top_key;
        logic [8:0]  item_count;
        logic        was_present;
    } rsp_t;

endpackage
`default_nettype wire

// ===== design/ibh_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ibh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/ibh_seq.sv =====
// Heap sequencer: membership bits, count and the sift walks over the slot and node RAMs.
`default_nettype none
`include "indexed_binary_max_heap_core_defines.svh"
module ibh_seq
    import ibh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      res_valid,
    input  wire logic res_ready,
    output rsp_t      res
);

    localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = PW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_POS, S_UP_A, S_UP_B, S_UP_C,
        S_REM1, S_REM2, S_REM3, S_DN_A, S_DN_B, S_DN_C, S_DN_D, S_DONE
    } state_t;

    function automatic logic [NW-1:0] node_wrap(input logic [7:0] v);
        logic [8:0] r;
        r = {1'b0, v};
        for (int i = 7; i >= 0; i--)
        begin
            if (32'(r) >= (NODE_COUNT << i))
            begin
                r = r - 9'(NODE_COUNT << i);
            end
        end
        return NW'(r);
    endfunction

    state_t                state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [KEY_BITS-1:0]   k_reg, k_next;
    logic [PW-1:0]         p_reg, p_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  pres_reg, pres_next;
    logic [NW-1:0]         q_reg, q_next;
    logic [NW-1:0]         r_reg, r_next;
    logic [KEY_BITS-1:0]   lk_reg, lk_next;
    logic [NW-1:0]         topn_reg, topn_next;
    logic [KEY_BITS-1:0]   topk_reg, topk_next;
    status_t               status_reg, status_next;
    logic [NODE_COUNT-1:0] member_reg;

    logic                mem_set, mem_clr;
    logic [NW-1:0]       mem_idx;

    logic                   slot_we;
    logic [PW-1:0]          slot_waddr, slot_raddr;
    logic [NW-1:0]          slot_wdata, slot_rdata;
    logic                   node_we;
    logic [NW-1:0]          node_waddr, node_raddr;
    logic [KEY_BITS-1:0]    node_wkey;
    logic [PW-1:0]          node_wpos;
    logic [KEY_BITS+PW-1:0] node_wdata, node_rdata;
    logic [KEY_BITS-1:0]    key_rdata;
    logic [PW-1:0]          pos_rdata;

    logic [PW-1:0] parent;
    logic [XW-1:0] left, right;
    logic          use_right;

    assign parent    = (p_reg - PW'(1)) >> 1;
    assign left      = {1'b0, p_reg, 1'b1};
    assign right     = left + XW'(1);
    assign use_right = (right < XW'(cnt_reg)) && (lk_reg < key_rdata);

    // Each node entry holds its key above its heap position.
    assign node_wdata = {node_wkey, node_wpos};
    assign key_rdata  = node_rdata[KEY_BITS+PW-1:PW];
    assign pos_rdata  = node_rdata[PW-1:0];

    ibh_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_slots (
        .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    ibh_ram #(.WIDTH(KEY_BITS + PW), .DEPTH(NODE_COUNT)) u_nodes (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .raddr(node_raddr), .rdata(node_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        p_next      = p_reg;
        cnt_next    = cnt_reg;
        pres_next   = pres_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        lk_next     = lk_reg;
        topn_next   = topn_reg;
        topk_next   = topk_reg;
        status_next = status_reg;
        mem_set     = 1'b0;
        mem_clr     = 1'b0;
        mem_idx     = n_reg;
        slot_we     = 1'b0;
        slot_waddr  = p_reg;
        slot_wdata  = n_reg;
        slot_raddr  = parent;
        node_we     = 1'b0;
        node_waddr  = n_reg;
        node_wkey   = k_reg;
        node_wpos   = p_reg;
        node_raddr  = slot_rdata;
        req_ready   = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next    = req.operation;
                    n_next     = node_wrap(req.node_id);
                    k_next     = KEY_BITS'(req.key);
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                pres_next   = member_reg[n_reg];
                topn_next   = '0;
                topk_next   = '0;
                status_next = ST_OK;
                state_next  = S_DONE;
                node_raddr  = n_reg;
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        if (member_reg[n_reg])
                        begin
                            status_next = ST_PRESENT;
                        end
                        else if (cnt_reg == CW'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            p_next     = PW'(cnt_reg);
                            cnt_next   = cnt_reg + CW'(1);
                            mem_set    = 1'b1;
                            state_next = S_UP_A;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            slot_raddr = '0;
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = S_REM1;
                        end
                    end
                    OP_UPDATE:
                    begin
                        if (!member_reg[n_reg])
                        begin
                            status_next = ST_ABSENT;
                        end
                        else
                        begin
                            state_next = S_POS;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_POS:
            begin
                p_next     = pos_rdata;
                state_next = S_UP_A;
            end
            S_UP_A:
            begin
                if (p_reg == '0)
                begin
                    slot_we    = 1'b1;
                    node_we    = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UP_B;
                end
            end
            S_UP_B:
            begin
                q_next     = slot_rdata;
                state_next = S_UP_C;
            end
            S_UP_C:
            begin
                // The moving node is held in registers; the parent drops into the hole.
                slot_we = 1'b1;
                node_we = 1'b1;
                if (k_reg > key_rdata)
                begin
                    slot_wdata = q_reg;
                    node_waddr = q_reg;
                    node_wkey  = key_rdata;
                    p_next     = parent;
                    state_next = S_UP_A;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_REM1:
            begin
                topn_next  = slot_rdata;
                mem_clr    = 1'b1;
                mem_idx    = slot_rdata;
                slot_raddr = PW'(cnt_reg);
                state_next = S_REM2;
            end
            S_REM2:
            begin
                topk_next  = key_rdata;
                n_next     = slot_rdata;
                state_next = (cnt_reg == '0) ? S_DONE : S_REM3;
            end
            S_REM3:
            begin
                k_next     = key_rdata;
                p_next     = '0;
                state_next = S_DN_A;
            end
            S_DN_A:
            begin
                slot_raddr = left[PW-1:0];
                if (left >= XW'(cnt_reg))
                begin
                    slot_we    = 1'b1;
                    node_we    = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_B;
                end
            end
            S_DN_B:
            begin
                q_next     = slot_rdata;
                slot_raddr = right[PW-1:0];
                state_next = S_DN_C;
            end
            S_DN_C:
            begin
                lk_next    = key_rdata;
                r_next     = slot_rdata;
                state_next = S_DN_D;
            end
            S_DN_D:
            begin
                slot_we = 1'b1;
                node_we = 1'b1;
                if (k_reg < (use_right ? key_rdata : lk_reg))
                begin
                    slot_wdata = use_right ? r_reg : q_reg;
                    node_waddr = use_right ? r_reg : q_reg;
                    node_wkey  = use_right ? key_rdata : lk_reg;
                    p_next     = use_right ? right[PW-1:0] : left[PW-1:0];
                    state_next = S_DN_A;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            member_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (mem_set)
            begin
                member_reg[mem_idx] <= 1'b1;
            end
            if (mem_clr)
            begin
                member_reg[mem_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        p_reg      <= p_next;
        pres_reg   <= pres_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        lk_reg     <= lk_next;
        topn_reg   <= topn_next;
        topk_reg   <= topk_next;
        status_reg <= status_next;
    end

    assign res.status      = status_reg;
    assign res.top_node    = 8'(topn_reg);
    assign res.top_key     = 16'(topk_reg);
    assign res.item_count  = 9'(cnt_reg);
    assign res.was_present = pres_reg;

    `IBH_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(CAPACITY))
    `IBH_ASSERT_NEXT(a_ins_member, clk, rst_n, mem_set, member_reg[n_reg])
    `IBH_ASSERT_IMPL(a_empty_cnt, clk, rst_n, state_reg == S_DONE && status_reg == ST_EMPTY, cnt_reg == '0)

endmodule
`default_nettype wire

// ===== design/indexed_binary_max_heap_core.sv =====
// Top level of the indexed max-heap core: sequencer plus the result register.
//
//   Channel | Handshake             | Payload | Direction
//   req     | req_valid / req_ready | req_t   | in
//   rsp     | rsp_valid / rsp_ready | rsp_t   | out
//
// One request is worked at a time; errors and the unused code go straight to the result.
// An insert climbs level by level until a parent stops the climb or it reaches the root,
// and an update first reads the node's stored position and then climbs the same way.
// A remove reads the top entry and then the last one; unless that empties the heap, the
// last entry sifts down until a child stops it, through chained slot-then-key reads.
// Reset clears the count, the membership bits and the control state; the RAMs need no clearing pass.
// A finished result sits in the output register, so the next request may start while the
// consumer stalls; the one after waits in the sequencer with the input held off.
`default_nettype none
module indexed_binary_max_heap_core
    import ibh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    logic rsp_valid_reg;
    rsp_t rsp_reg;
    logic res_valid;
    logic res_ready;
    rsp_t res;

    ibh_seq u_seq (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire
